/* hdl/command_retry_queue_core_defines.svh */
// ----------------------------------------------------------------------------
// Command retry queue assertion macros
// Assertion wrappers shared by the command retry queue RTL. Defining
// ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef COMMAND_RETRY_QUEUE_CORE_DEFINES_SVH
`define COMMAND_RETRY_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define CRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CRQ_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CRQ_ASSERT(name, prop, msg)
`define CRQ_ASSERT_NR(name, prop, msg)
`endif

`endif

/* hdl/crq_pkg.sv */
// ----------------------------------------------------------------------------
// Command retry queue package
// Sizes, codes, entry layout and ring index helpers for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crq_pkg;

  // Ring geometry: DEPTH slots, at most DEPTH-1 entries held.
  localparam int unsigned DEPTH = 8;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  // Longest accepted payload, in bytes.
  localparam logic [11:0] MAX_LEN = 12'd256;

  typedef enum logic [2:0] {
    ACT_INS_TAIL  = 3'd0,
    ACT_INS_FRONT = 3'd1,
    ACT_TICK      = 3'd2,
    ACT_SEND_POLL = 3'd3,
    ACT_REPLY     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    EV_NOTHING   = 3'd0,
    EV_INSERTED  = 3'd1,
    EV_REJECTED  = 3'd2,
    EV_SENT      = 3'd3,
    EV_COMPLETED = 3'd4,
    EV_FAILED    = 3'd5,
    EV_RETRY     = 3'd6,
    EV_IGNORED   = 3'd7
  } event_e;

  // One queued command.
  typedef struct packed {
    logic [15:0] handle;
    logic [11:0] length;
    logic [15:0] timeout;
    logic [7:0]  retries;
  } entry_t;

  // Up to two slot writes per cycle (a front insert behind the active entry).
  typedef struct packed {
    logic             we0;
    logic [IDX_W-1:0] addr0;
    entry_t           data0;
    logic             we1;
    logic [IDX_W-1:0] addr1;
    entry_t           data1;
  } store_wr_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
    ring_prev = (idx == '0) ? IDX_LAST : idx - IDX_W'(1);
  endfunction

endpackage

/* hdl/crq_in_if.sv */
// ----------------------------------------------------------------------------
// Command retry queue input channel
// Valid/ready channel carrying one action item into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] cmd_handle;
  logic [11:0] cmd_length;
  logic [15:0] reply_timeout;
  logic [7:0]  retry_limit;
  logic        link_tx_idle;
  logic        link_rx_pending;
  logic        reply_accepted;

  modport source (
    output valid, action, cmd_handle, cmd_length, reply_timeout, retry_limit,
           link_tx_idle, link_rx_pending, reply_accepted,
    input  ready
  );

  modport sink (
    input  valid, action, cmd_handle, cmd_length, reply_timeout, retry_limit,
           link_tx_idle, link_rx_pending, reply_accepted,
    output ready
  );
endinterface

/* hdl/crq_out_if.sv */
// ----------------------------------------------------------------------------
// Command retry queue result channel
// Valid/ready channel carrying one result item out of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface crq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] entry_handle;
  logic [11:0] entry_length;
  logic        awaiting_reply;
  logic        placed_behind_active;

  modport source (
    output valid, event_res, entry_handle, entry_length, awaiting_reply,
           placed_behind_active,
    input  ready
  );

  modport sink (
    input  valid, event_res, entry_handle, entry_length, awaiting_reply,
           placed_behind_active,
    output ready
  );
endinterface

/* hdl/crq_store.sv */
// ----------------------------------------------------------------------------
// Command retry queue entry store
// Flip-flop slot array with two write ports and one read at the ring head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crq_store (
  input  logic                          clk_i,
  input  crq_pkg::store_wr_t            wr_i,
  input  logic [crq_pkg::IDX_W-1:0]     rd_addr_i,
  output crq_pkg::entry_t               rd_data_o
);

  crq_pkg::entry_t slot_q [crq_pkg::DEPTH];

  // Slots hold payload only; contents are undefined until first written.
  always_ff @(posedge clk_i) begin
    if (wr_i.we0) begin
      slot_q[wr_i.addr0] <= wr_i.data0;
    end
    if (wr_i.we1) begin
      slot_q[wr_i.addr1] <= wr_i.data1;
    end
  end

  // Head entry read, used in the same cycle by the control logic.
  assign rd_data_o = slot_q[rd_addr_i];

endmodule

/* hdl/command_retry_queue_core.sv */
// ----------------------------------------------------------------------------
// Command retry queue core
// Master-side command ring with reply timeout and retry. Each action item
// (tail insert, front insert, tick, send poll, reply) is handled in the cycle
// it is accepted and gives exactly one result item, held in an output
// register. One item is taken per clock; the only limit on rate is the
// result register, which frees as soon as the sink takes its item, so a
// stalled sink stops the input after one item. There is no clearing pass
// after reset: the ring starts empty and slots are written before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "command_retry_queue_core_defines.svh"

module command_retry_queue_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  crq_in_if.sink    cmd_i,
  crq_out_if.source res_o
);

  localparam int unsigned IW = crq_pkg::IDX_W;

  // Control state.
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [15:0]   cnt_q, cnt_d;
  logic          waiting_q, waiting_d;
  logic          behind_q, behind_d;

  // Result register.
  logic             out_valid_q;
  crq_pkg::event_e  ev_q, ev_d;
  logic [15:0]      oh_q, oh_d;
  logic [11:0]      ol_q, ol_d;
  logic             ow_q;
  logic             ob_q;

  logic               cmd_fire;
  crq_pkg::action_e   act;
  crq_pkg::entry_t    fresh;
  crq_pkg::entry_t    head_ent;
  crq_pkg::entry_t    head_dec;
  crq_pkg::store_wr_t wr;
  logic               ring_empty;
  logic               ring_full;
  logic               bad_insert;

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign act         = crq_pkg::action_e'(cmd_i.action);

  assign fresh.handle  = cmd_i.cmd_handle;
  assign fresh.length  = cmd_i.cmd_length;
  assign fresh.timeout = cmd_i.reply_timeout;
  assign fresh.retries = cmd_i.retry_limit;

  assign ring_empty = (head_q == tail_q);
  assign ring_full  = (head_q == crq_pkg::ring_next(tail_q));
  assign bad_insert = (cmd_i.cmd_length == 12'd0) ||
                      (cmd_i.cmd_length > crq_pkg::MAX_LEN) || ring_full;

  crq_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (head_q),
    .rd_data_o (head_ent)
  );

  // Head entry with one retry used up.
  always_comb begin
    head_dec         = head_ent;
    head_dec.retries = head_ent.retries - 8'd1;
  end

  // Action decode: next state, slot writes and the result item.
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    waiting_d = waiting_q;
    behind_d  = behind_q;
    ev_d      = crq_pkg::EV_NOTHING;
    oh_d      = '0;
    ol_d      = '0;
    wr        = '0;

    unique case (act) inside
      crq_pkg::ACT_INS_TAIL, crq_pkg::ACT_INS_FRONT: begin
        if (bad_insert) begin
          ev_d = crq_pkg::EV_REJECTED;
        end else begin
          ev_d = crq_pkg::EV_INSERTED;
          oh_d = fresh.handle;
          ol_d = fresh.length;
          if (act == crq_pkg::ACT_INS_TAIL) begin
            wr.we0   = 1'b1;
            wr.addr0 = tail_q;
            wr.data0 = fresh;
            tail_d   = crq_pkg::ring_next(tail_q);
          end else begin
            head_d = crq_pkg::ring_prev(head_q);
            if (waiting_q) begin
              // Active entry moves one slot forward, the new one sits behind it.
              wr.we0   = 1'b1;
              wr.addr0 = crq_pkg::ring_prev(head_q);
              wr.data0 = head_ent;
              wr.we1   = 1'b1;
              wr.addr1 = head_q;
              wr.data1 = fresh;
              behind_d = 1'b1;
            end else begin
              wr.we0   = 1'b1;
              wr.addr0 = crq_pkg::ring_prev(head_q);
              wr.data0 = fresh;
              behind_d = 1'b0;
            end
          end
        end
      end

      crq_pkg::ACT_TICK: begin
        if (cnt_q != 16'd0) begin
          cnt_d = cnt_q - 16'd1;
        end
      end

      crq_pkg::ACT_SEND_POLL: begin
        if (!waiting_q) begin
          if (!ring_empty && cmd_i.link_tx_idle && !cmd_i.link_rx_pending) begin
            cnt_d     = head_ent.timeout;
            waiting_d = 1'b1;
            ev_d      = crq_pkg::EV_SENT;
            oh_d      = head_ent.handle;
            ol_d      = head_ent.length;
          end
        end else if (cnt_q == 16'd0) begin
          // Reply wait expired.
          if (!ring_empty) begin
            oh_d = head_ent.handle;
            ol_d = head_ent.length;
            if (head_ent.retries == 8'd0) begin
              ev_d   = crq_pkg::EV_FAILED;
              head_d = crq_pkg::ring_next(head_q);
            end else begin
              ev_d     = crq_pkg::EV_RETRY;
              wr.we0   = 1'b1;
              wr.addr0 = head_q;
              wr.data0 = head_dec;
            end
          end
          waiting_d = 1'b0;
        end
      end

      crq_pkg::ACT_REPLY: begin
        if (!waiting_q || ring_empty) begin
          ev_d = crq_pkg::EV_IGNORED;
        end else begin
          oh_d = head_ent.handle;
          ol_d = head_ent.length;
          if (cmd_i.reply_accepted) begin
            ev_d   = crq_pkg::EV_COMPLETED;
            head_d = crq_pkg::ring_next(head_q);
          end else if (head_ent.retries == 8'd0) begin
            ev_d   = crq_pkg::EV_FAILED;
            head_d = crq_pkg::ring_next(head_q);
          end else begin
            ev_d     = crq_pkg::EV_RETRY;
            wr.we0   = 1'b1;
            wr.addr0 = head_q;
            wr.data0 = head_dec;
          end
        end
        waiting_d = 1'b0;
      end

      default: begin
        ev_d = crq_pkg::EV_NOTHING;
      end
    endcase

    // Nothing changes unless an item is actually taken.
    if (!cmd_fire) begin
      wr.we0 = 1'b0;
      wr.we1 = 1'b0;
    end
  end

  // Queue control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      waiting_q <= 1'b0;
      behind_q  <= 1'b0;
    end else if (cmd_fire) begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      waiting_q <= waiting_d;
      behind_q  <= behind_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      ev_q <= ev_d;
      oh_q <= oh_d;
      ol_q <= ol_d;
      ow_q <= waiting_d;
      ob_q <= behind_d;
    end
  end

  assign res_o.valid                = out_valid_q;
  assign res_o.event_res            = ev_q;
  assign res_o.entry_handle         = oh_q;
  assign res_o.entry_length         = ol_q;
  assign res_o.awaiting_reply       = ow_q;
  assign res_o.placed_behind_active = ob_q;

  // A reply is only awaited for an entry that is still in the ring.
  `CRQ_ASSERT_NR(a_wait_nonempty, waiting_q |-> (head_q != tail_q), "waiting on empty ring")

  // A full ring turns any insert into a rejection.
  `CRQ_ASSERT(a_full_rejects,
    cmd_fire && ring_full &&
    (act == crq_pkg::ACT_INS_TAIL || act == crq_pkg::ACT_INS_FRONT) |=>
    out_valid_q && (ev_q == crq_pkg::EV_REJECTED),
    "insert into full ring not rejected")

  // A tick on a running countdown lowers it by exactly one.
  `CRQ_ASSERT(a_tick_dec,
    cmd_fire && (act == crq_pkg::ACT_TICK) && (cnt_q != 16'd0) |=>
    cnt_q == $past(cnt_q) - 16'd1,
    "tick did not decrement countdown")

  // The behind flag is only raised while a reply is awaited.
  `CRQ_ASSERT(a_behind_waiting, $rose(behind_q) |-> waiting_q, "behind flag set while idle")

  // A successful send leaves the master waiting for a reply.
  `CRQ_ASSERT(a_sent_waits,
    cmd_fire && (ev_d == crq_pkg::EV_SENT) |=> waiting_q && ow_q,
    "send did not enter reply wait")

endmodule

/* bench/command_retry_queue_core_test.sv */
// ----------------------------------------------------------------------------
// Command retry queue core testbench
// Drives tail and front inserts, ticks, send polls and replies into the
// queue and checks every result item against a cycle-free model of the ring.
// The model tracks the entries, the reply countdown and the wait state.
// Both sides idle in random bursts. The result side also holds off once for
// a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_retry_queue_core_test;

  // Action codes that the block does not use.
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_ITEMS  = 100;
  localparam int HOLD_AFTER   = 250;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  // One action item as offered to the block.
  typedef struct {
    logic [2:0]  action;
    logic [15:0] handle;
    logic [11:0] length;
    logic [15:0] timeout;
    logic [7:0]  retries;
    logic        tx_idle;
    logic        rx_pending;
    logic        accepted;
  } queue_action_t;

  // One result item as produced by the block.
  typedef struct {
    crq_pkg::event_e ev;
    logic [15:0]     handle;
    logic [11:0]     length;
    logic            awaiting;
    logic            behind;
  } queue_event_t;

  // Model of the command ring and the queue of events it still owes.
  class cmd_ring_scoreboard;
    crq_pkg::entry_t           slots[crq_pkg::DEPTH];
    logic [crq_pkg::IDX_W-1:0] head_idx;
    logic [crq_pkg::IDX_W-1:0] tail_idx;
    logic [15:0]               countdown;
    logic                      waiting;
    logic                      behind;
    queue_event_t              owed_events[$];
    int                        error_count;

    function new();
      foreach (slots[i]) slots[i] = '0;
      head_idx    = '0;
      tail_idx    = '0;
      countdown   = '0;
      waiting     = 1'b0;
      behind      = 1'b0;
      error_count = 0;
    endfunction

    function logic [crq_pkg::IDX_W-1:0] fwd(input logic [crq_pkg::IDX_W-1:0] i);
      return crq_pkg::IDX_W'((int'(i) + 1) % crq_pkg::DEPTH);
    endfunction

    function logic [crq_pkg::IDX_W-1:0] back(input logic [crq_pkg::IDX_W-1:0] i);
      return crq_pkg::IDX_W'((int'(i) + crq_pkg::DEPTH - 1) % crq_pkg::DEPTH);
    endfunction

    function int pending_count();
      return owed_events.size();
    endfunction

    // Head entry used up a retry, or leaves the ring as failed.
    function void retry_or_fail(ref queue_event_t r);
      if (slots[head_idx].retries == 8'd0) begin
        r.ev     = crq_pkg::EV_FAILED;
        head_idx = fwd(head_idx);
      end else begin
        slots[head_idx].retries = slots[head_idx].retries - 8'd1;
        r.ev = crq_pkg::EV_RETRY;
      end
    endfunction

    // Applies one accepted action and records the event it must produce.
    function void note_action(input queue_action_t a);
      queue_event_t              r;
      crq_pkg::entry_t           fresh;
      logic [crq_pkg::IDX_W-1:0] slot_behind;
      logic                      is_empty;
      r.ev       = crq_pkg::EV_NOTHING;
      r.handle   = '0;
      r.length   = '0;
      fresh      = '{handle: a.handle, length: a.length, timeout: a.timeout,
                     retries: a.retries};
      is_empty   = (head_idx == tail_idx);
      case (a.action) inside
        crq_pkg::ACT_INS_TAIL, crq_pkg::ACT_INS_FRONT: begin
          if (a.length == '0 || a.length > crq_pkg::MAX_LEN ||
              head_idx == fwd(tail_idx)) begin
            r.ev = crq_pkg::EV_REJECTED;
          end else begin
            if (a.action == crq_pkg::ACT_INS_TAIL) begin
              slots[tail_idx] = fresh;
              tail_idx = fwd(tail_idx);
            end else begin
              head_idx = back(head_idx);
              if (waiting) begin
                // The active entry keeps the head; the urgent one goes right behind it.
                slot_behind        = fwd(head_idx);
                slots[head_idx]    = slots[slot_behind];
                slots[slot_behind] = fresh;
                behind             = 1'b1;
              end else begin
                slots[head_idx] = fresh;
                behind          = 1'b0;
              end
            end
            r.ev     = crq_pkg::EV_INSERTED;
            r.handle = a.handle;
            r.length = a.length;
          end
        end
        crq_pkg::ACT_TICK: begin
          if (countdown != '0) countdown = countdown - 16'd1;
        end
        crq_pkg::ACT_SEND_POLL: begin
          if (!waiting) begin
            if (!is_empty && a.tx_idle && !a.rx_pending) begin
              countdown = slots[head_idx].timeout;
              waiting   = 1'b1;
              r.ev      = crq_pkg::EV_SENT;
              r.handle  = slots[head_idx].handle;
              r.length  = slots[head_idx].length;
            end
          end else if (countdown == '0) begin
            // Reply wait expired.
            if (!is_empty) begin
              r.handle = slots[head_idx].handle;
              r.length = slots[head_idx].length;
              retry_or_fail(r);
            end
            waiting = 1'b0;
          end
        end
        crq_pkg::ACT_REPLY: begin
          if (!waiting || is_empty) begin
            r.ev = crq_pkg::EV_IGNORED;
          end else begin
            r.handle = slots[head_idx].handle;
            r.length = slots[head_idx].length;
            if (a.accepted) begin
              r.ev     = crq_pkg::EV_COMPLETED;
              head_idx = fwd(head_idx);
            end else begin
              retry_or_fail(r);
            end
          end
          waiting = 1'b0;
        end
        default: begin
        end
      endcase
      r.awaiting = waiting;
      r.behind   = behind;
      owed_events.push_back(r);
    endfunction

    // Compares one result item with the oldest owed event.
    function void check_event(input queue_event_t got);
      queue_event_t exp;
      if (owed_events.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result: event %0d handle %h length %0d",
                   got.ev, got.handle, got.length);
        return;
      end
      exp = owed_events.pop_front();
      if (got.ev !== exp.ev || got.handle !== exp.handle || got.length !== exp.length ||
          got.awaiting !== exp.awaiting || got.behind !== exp.behind) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display({"mismatch: expected ev %0d handle %h len %0d wait %b behind %b, ",
                    "got ev %0d handle %h len %0d wait %b behind %b"},
                   exp.ev, exp.handle, exp.length, exp.awaiting, exp.behind,
                   got.ev, got.handle, got.length, got.awaiting, got.behind);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  crq_in_if  cmd ();
  crq_out_if res ();

  command_retry_queue_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .res_o  (res)
  );

  cmd_ring_scoreboard ring_sb = new();

  int items_accepted = 0;
  bit quiet_phase    = 1'b0;
  bit long_hold_done = 1'b0;
  int cycle_count    = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic queue_action_t make_action(
    input logic [2:0] action, input logic [15:0] handle, input logic [11:0] length,
    input logic [15:0] timeout, input logic [7:0] retries,
    input logic tx_idle, input logic rx_pending, input logic accepted);
    queue_action_t a;
    a.action     = action;
    a.handle     = handle;
    a.length     = length;
    a.timeout    = timeout;
    a.retries    = retries;
    a.tx_idle    = tx_idle;
    a.rx_pending = rx_pending;
    a.accepted   = accepted;
    return a;
  endfunction

  // Mostly well-formed actions with short timeouts and few retries, so that
  // sends, expiries, retries and failures all come up often.
  function automatic queue_action_t random_action();
    queue_action_t a;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < 28)      a.action = crq_pkg::ACT_INS_TAIL;
    else if (pick < 36) a.action = crq_pkg::ACT_INS_FRONT;
    else if (pick < 64) a.action = crq_pkg::ACT_TICK;
    else if (pick < 82) a.action = crq_pkg::ACT_SEND_POLL;
    else if (pick < 97) a.action = crq_pkg::ACT_REPLY;
    else                a.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    a.handle = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 6)       a.length = '0;
    else if (pick < 14) a.length = 12'($urandom_range(int'(crq_pkg::MAX_LEN) + 1, 4095));
    else                a.length = 12'($urandom_range(1, int'(crq_pkg::MAX_LEN)));
    pick = $urandom_range(0, 99);
    if (pick < 85)      a.timeout = 16'($urandom_range(0, 4));
    else                a.timeout = 16'($urandom_range(0, 65535));
    a.retries    = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 2))
                                               : 8'($urandom_range(0, 255));
    a.tx_idle    = ($urandom_range(0, 9) != 0);
    a.rx_pending = ($urandom_range(0, 9) == 0);
    a.accepted   = ($urandom_range(0, 2) != 0);
    return a;
  endfunction

  // Offers one item from the falling edge until the block takes it.
  task automatic drive_item(input queue_action_t a);
    @(negedge clk_i);
    cmd.valid           = 1'b1;
    cmd.action          = a.action;
    cmd.cmd_handle      = a.handle;
    cmd.cmd_length      = a.length;
    cmd.reply_timeout   = a.timeout;
    cmd.retry_limit     = a.retries;
    cmd.link_tx_idle    = a.tx_idle;
    cmd.link_rx_pending = a.rx_pending;
    cmd.reply_accepted  = a.accepted;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
    ring_sb.note_action(a);
    items_accepted++;
  endtask

  // Result monitor.
  always @(posedge clk_i) begin
    queue_event_t got;
    if (rst_ni && res.valid && res.ready) begin
      got.ev       = crq_pkg::event_e'(res.event_res);
      got.handle   = res.entry_handle;
      got.length   = res.entry_length;
      got.awaiting = res.awaiting_reply;
      got.behind   = res.placed_behind_active;
      ring_sb.check_event(got);
    end
  end

  // Result side: ready stretches broken by short stalls, and one long hold.
  initial begin
    res.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      res.ready = 1'b1;
      repeat ($urandom_range(0, 40)) @(negedge clk_i);
      if (quiet_phase) continue;
      @(negedge clk_i);
      res.ready = 1'b0;
      if (!long_hold_done && items_accepted >= HOLD_AFTER) begin
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        repeat ($urandom_range(0, 14)) @(negedge clk_i);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    queue_action_t stimulus[$];
    rst_ni              = 1'b0;
    cmd.valid           = 1'b0;
    cmd.action          = crq_pkg::ACT_TICK;
    cmd.cmd_handle      = '0;
    cmd.cmd_length      = '0;
    cmd.reply_timeout   = '0;
    cmd.retry_limit     = '0;
    cmd.link_tx_idle    = 1'b0;
    cmd.link_rx_pending = 1'b0;
    cmd.reply_accepted  = 1'b0;

    // Idle-state actions: a reply, a poll on an empty ring, a tick, a spare code.
    stimulus.push_back(make_action(crq_pkg::ACT_REPLY, '0, '0, '0, '0,
                                   1'b1, 1'b0, 1'b1));
    stimulus.push_back(make_action(crq_pkg::ACT_SEND_POLL, '0, '0, '0, '0,
                                   1'b1, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_TICK, '0, '0, '0, '0,
                                   1'b0, 1'b0, 1'b0));
    stimulus.push_back(make_action(ACT_SPARE_HI, 16'hFFFF, 12'hFFF, 16'hFFFF, 8'hFF,
                                   1'b1, 1'b1, 1'b1));
    // Bad lengths are rejected.
    stimulus.push_back(make_action(crq_pkg::ACT_INS_TAIL, 16'h0001, '0, 16'd3, 8'd1,
                                   1'b0, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_INS_TAIL, 16'h0002,
                                   crq_pkg::MAX_LEN + 12'd1, 16'd3, 8'd1,
                                   1'b0, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_INS_FRONT, 16'h0003, 12'hFFF, 16'd3, 8'd1,
                                   1'b0, 1'b0, 1'b0));
    // Largest and smallest good entries.
    stimulus.push_back(make_action(crq_pkg::ACT_INS_TAIL, 16'hFFFF, crq_pkg::MAX_LEN,
                                   16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_INS_TAIL, 16'h0000, 12'd1, '0, '0,
                                   1'b0, 1'b0, 1'b0));
    // A poll is held off by a busy transmitter or a pending receive.
    stimulus.push_back(make_action(crq_pkg::ACT_SEND_POLL, '0, '0, '0, '0,
                                   1'b0, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_SEND_POLL, '0, '0, '0, '0,
                                   1'b1, 1'b1, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_SEND_POLL, '0, '0, '0, '0,
                                   1'b1, 1'b0, 1'b0));
    // Urgent insert while waiting goes behind the active entry.
    stimulus.push_back(make_action(crq_pkg::ACT_INS_FRONT, 16'h1234, 12'd16, 16'd2, 8'd1,
                                   1'b0, 1'b0, 1'b0));
    // Refused reply, resend, then an accepted reply.
    stimulus.push_back(make_action(crq_pkg::ACT_REPLY, '0, '0, '0, '0,
                                   1'b0, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_SEND_POLL, '0, '0, '0, '0,
                                   1'b1, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_REPLY, '0, '0, '0, '0,
                                   1'b0, 1'b0, 1'b1));
    // Urgent insert while idle takes the head; it expires with no retry left.
    stimulus.push_back(make_action(crq_pkg::ACT_INS_FRONT, 16'h00A5, 12'd8, '0, '0,
                                   1'b0, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_SEND_POLL, '0, '0, '0, '0,
                                   1'b1, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_SEND_POLL, '0, '0, '0, '0,
                                   1'b1, 1'b0, 1'b0));
    // Fill the ring, then both inserts are rejected as full.
    for (int i = 0; i < 6; i++)
      stimulus.push_back(make_action(crq_pkg::ACT_INS_TAIL, 16'(16'h5A00 + i),
                                     12'(i + 2), 16'd1, 8'd2, 1'b0, 1'b0, 1'b0));
    stimulus.push_back(make_action(crq_pkg::ACT_INS_FRONT, 16'h7777, 12'd4, 16'd1, 8'd1,
                                   1'b0, 1'b0, 1'b0));
    for (int i = 0; i < RANDOM_ITEMS; i++)
      stimulus.push_back(random_action());

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stimulus[i]) begin
      if (i >= stimulus.size() - QUIET_ITEMS) quiet_phase = 1'b1;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 15)) begin
          @(negedge clk_i);
          cmd.valid = 1'b0;
        end
      end
      drive_item(stimulus[i]);
    end
    @(negedge clk_i);
    cmd.valid = 1'b0;

    while (ring_sb.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (ring_sb.error_count == 0 && ring_sb.pending_count() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
